// File: hw/rtl/magnetometer_heading_top_defines.svh
// Assertion macros shared by the verification side of the heading block.
// Each macro is clocked on clk and switched off while rst_n is low.
`ifndef MAGNETOMETER_HEADING_TOP_DEFINES_SVH
`define MAGNETOMETER_HEADING_TOP_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define MHD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MHD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MHD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mhd_pkg.sv
package mhd_pkg;

    localparam int CORDIC_STEPS = 16;   // 8..24

    localparam int RAW_W       = 16;
    localparam int DIFF_W      = 17;
    localparam int FRAC_SHIFT  = 16;
    localparam int XY_W        = 36;
    localparam int Z_W         = 30;
    localparam int ANG_W       = 31;
    localparam int NUM_W       = 29;
    localparam int HDG_W       = 16;
    localparam int SUM_W       = 18;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 40;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int REM_W       = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // angles in micro-degrees
    localparam logic signed [Z_W-1:0] MICRO_180   = Z_W'(180000000);
    localparam logic [ANG_W-1:0]      MICRO_270   = ANG_W'(270000000);
    localparam logic [ANG_W-1:0]      MICRO_360   = ANG_W'(360000000);
    localparam logic [NUM_W-1:0]      ROUND_HALF  = NUM_W'(5000);
    localparam logic [NUM_W-1:0]      MICRO_PER_HDG = NUM_W'(10000);
    // floor(2^40 / 10000); quotient estimate is exact or one low
    localparam logic [RECIP_W-1:0]    RECIP_10K   = RECIP_W'(109951162);

    localparam logic [HDG_W-1:0] HEADING_FULL     = HDG_W'(36000);
    localparam logic [HDG_W-1:0] HEADING_ZERO_VEC = HDG_W'(27000);

    localparam logic [RAW_W-1:0]        OFFSET_RESET = RAW_W'(32768);
    localparam logic signed [RAW_W-1:0] DECL_RESET   = -16'sd7000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X    = 2'd0,
        CFG_OFFSET_Y    = 2'd1,
        CFG_DECLINATION = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } cordic_data_t;

    // atan(2^-i) in micro-degrees
    function automatic logic signed [Z_W-1:0] atan_micro(input int idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            0:       val = Z_W'(45000000);
            1:       val = Z_W'(26565051);
            2:       val = Z_W'(14036243);
            3:       val = Z_W'(7125016);
            4:       val = Z_W'(3576334);
            5:       val = Z_W'(1789911);
            6:       val = Z_W'(895174);
            7:       val = Z_W'(447614);
            8:       val = Z_W'(223811);
            9:       val = Z_W'(111906);
            10:      val = Z_W'(55953);
            11:      val = Z_W'(27976);
            12:      val = Z_W'(13988);
            13:      val = Z_W'(6994);
            14:      val = Z_W'(3497);
            15:      val = Z_W'(1749);
            16:      val = Z_W'(874);
            17:      val = Z_W'(437);
            18:      val = Z_W'(219);
            19:      val = Z_W'(109);
            20:      val = Z_W'(55);
            21:      val = Z_W'(27);
            22:      val = Z_W'(14);
            23:      val = Z_W'(7);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: hw/rtl/mhd_in_if.sv
interface mhd_in_if;
    logic                       valid;
    logic                       ready;
    logic [mhd_pkg::RAW_W-1:0]  raw_x;
    logic [mhd_pkg::RAW_W-1:0]  raw_y;

    modport source (output valid, output raw_x, output raw_y, input ready);
    modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

// File: hw/rtl/mhd_out_if.sv
interface mhd_out_if;
    logic                       valid;
    logic                       ready;
    logic [mhd_pkg::HDG_W-1:0]  heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

// File: hw/rtl/mhd_cordic.sv
module mhd_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mhd_pkg::cordic_data_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mhd_pkg::cordic_data_t out_data
);
    import mhd_pkg::*;

    cordic_data_t stage_reg  [CORDIC_STEPS];
    cordic_data_t stage_next [CORDIC_STEPS];
    logic         valid_reg  [CORDIC_STEPS];
    logic [CORDIC_STEPS:0] ready;

    assign ready[CORDIC_STEPS] = out_ready;
    assign in_ready            = ready[0];
    assign out_valid           = valid_reg[CORDIC_STEPS-1];
    assign out_data            = stage_reg[CORDIC_STEPS-1];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        cordic_data_t           prev;
        logic                   prev_valid;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic                   rot_neg;

        if (i == 0) begin : g_first
            assign prev       = in_data;
            assign prev_valid = in_valid;
        end else begin : g_rest
            assign prev       = stage_reg[i-1];
            assign prev_valid = valid_reg[i-1];
        end

        assign xs      = $signed(prev.x) >>> i;
        assign ys      = $signed(prev.y) >>> i;
        // y > 0 rotates clockwise
        assign rot_neg = !prev.y[XY_W-1] && (prev.y != '0);

        always_comb
        begin
            stage_next[i] = prev;
            if (rot_neg)
            begin
                stage_next[i].x = prev.x + ys;
                stage_next[i].y = prev.y - xs;
                stage_next[i].z = prev.z + atan_micro(i);
            end
            else
            begin
                stage_next[i].x = prev.x - ys;
                stage_next[i].y = prev.y + xs;
                stage_next[i].z = prev.z - atan_micro(i);
            end
        end

        // a stage loads when empty or when its content moves on
        assign ready[i] = !valid_reg[i] || ready[i+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (ready[i])
            begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready[i] && prev_valid)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

endmodule

// File: hw/rtl/magnetometer_heading_top.sv
// Magnetometer compass heading.
// sample: valid/ready transaction carrying raw_x and raw_y (unsigned counts).
// result: valid/ready transaction carrying heading in hundredths of a degree,
//         0..36000, one result per sample, in sample order.
// cfg_we/cfg_index/cfg_data: write-only registers offset_x (0), offset_y (1)
//         and declination (2); index 3 is ignored. Write only while idle.
// The pipeline holds one offset stage, one register per CORDIC micro-rotation,
// then wrap/round, reciprocal multiply, quotient correction and declination
// stages. Throughput is one sample per cycle while the receiver takes results;
// every stage is registered and the slowest step is the 29x27 reciprocal
// multiply.
// When the receiver stalls, the result holds in the output register and
// samples keep entering until every empty stage ahead has filled; sample.ready
// drops only once the whole pipeline is full.
// Reset empties the pipeline and restores offsets to 32768 and declination
// to -7000.
module magnetometer_heading_top (
    input  logic                              clk,
    input  logic                              rst_n,
    mhd_in_if.sink                            sample,
    mhd_out_if.source                         result,
    input  logic                              cfg_we,
    input  logic [mhd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mhd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mhd_pkg::*;

    // configuration
    logic [RAW_W-1:0]        offset_x_reg;
    logic [RAW_W-1:0]        offset_y_reg;
    logic signed [RAW_W-1:0] decl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= OFFSET_RESET;
            offset_y_reg <= OFFSET_RESET;
            decl_reg     <= DECL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OFFSET_X:    offset_x_reg <= cfg_data;
                CFG_OFFSET_Y:    offset_y_reg <= cfg_data;
                CFG_DECLINATION: decl_reg     <= $signed(cfg_data);
                default:         ;
            endcase
        end
    end

    // stage readiness, back to front
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic prep_valid_reg, f1_valid_reg, f2_valid_reg, f3_valid_reg, f4_valid_reg;
    logic cordic_in_ready, cordic_out_valid;
    cordic_data_t cordic_out;

    assign rdy4 = !f4_valid_reg || result.ready;
    assign rdy3 = !f3_valid_reg || rdy4;
    assign rdy2 = !f2_valid_reg || rdy3;
    assign rdy1 = !f1_valid_reg || rdy2;
    assign rdy0 = !prep_valid_reg || cordic_in_ready;

    assign sample.ready = rdy0;

    // prep: offset removal, fold left half-plane onto the right
    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [XY_W-1:0]   dx_ext, dy_ext;
    logic                     flip;
    cordic_data_t             prep_next, prep_reg;

    assign dx     = $signed({1'b0, sample.raw_x}) - $signed({1'b0, offset_x_reg});
    assign dy     = $signed({1'b0, sample.raw_y}) - $signed({1'b0, offset_y_reg});
    assign dx_ext = {{(XY_W-DIFF_W){dx[DIFF_W-1]}}, dx};
    assign dy_ext = {{(XY_W-DIFF_W){dy[DIFF_W-1]}}, dy};
    assign flip   = dx[DIFF_W-1];

    always_comb
    begin
        prep_next.x    = (flip ? -dx_ext : dx_ext) <<< FRAC_SHIFT;
        prep_next.y    = (flip ? -dy_ext : dy_ext) <<< FRAC_SHIFT;
        prep_next.z    = flip ? MICRO_180 : '0;
        prep_next.zero = (dx == '0) && (dy == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (rdy0)
        begin
            prep_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && sample.valid)
        begin
            prep_reg <= prep_next;
        end
    end

    mhd_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid_reg),
        .in_ready  (cordic_in_ready),
        .in_data   (prep_reg),
        .out_valid (cordic_out_valid),
        .out_ready (rdy1),
        .out_data  (cordic_out)
    );

    // f1: +270 deg, wrap into the circle, add half a hundredth
    logic [ANG_W-1:0] ang;
    logic [ANG_W-1:0] ang_wrap;
    logic [NUM_W-1:0] f1_num_next, f1_num_reg;
    logic             f1_zero_reg;

    assign ang         = MICRO_270 + ANG_W'(cordic_out.z);
    assign ang_wrap    = (ang >= MICRO_360) ? (ang - MICRO_360) : ang;
    assign f1_num_next = NUM_W'(ang_wrap) + ROUND_HALF;

    // f2: quotient estimate by reciprocal multiply
    logic [PROD_W-1:0] prod;
    logic [HDG_W-1:0]  f2_q_reg;
    logic [NUM_W-1:0]  f2_num_reg;
    logic              f2_zero_reg;

    assign prod = PROD_W'(f1_num_reg) * PROD_W'(RECIP_10K);

    // f3: correct estimate by one, wrap 36000, zero-vector override
    logic [NUM_W-1:0] back;
    logic [NUM_W-1:0] rem;
    logic [HDG_W-1:0] q_fix;
    logic [HDG_W-1:0] f3_base_next, f3_base_reg;

    assign back = NUM_W'(f2_q_reg) * MICRO_PER_HDG;
    assign rem  = f2_num_reg - back;
    assign q_fix = f2_q_reg
                 + HDG_W'(rem[REM_W-1:0] >= MICRO_PER_HDG[REM_W-1:0]);

    always_comb
    begin
        if (f2_zero_reg)
        begin
            f3_base_next = HEADING_ZERO_VEC;
        end
        else if (q_fix >= HEADING_FULL)
        begin
            f3_base_next = '0;
        end
        else
        begin
            f3_base_next = q_fix;
        end
    end

    // f4: declination and single wrap
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_wrap;
    logic [HDG_W-1:0]        heading_reg;

    assign sum = $signed({2'b00, f3_base_reg})
               + {{(SUM_W-RAW_W){decl_reg[RAW_W-1]}}, decl_reg};

    always_comb
    begin
        sum_wrap = sum;
        if (!decl_reg[RAW_W-1] && (decl_reg != '0))
        begin
            if (sum > $signed({2'b00, HEADING_FULL}))
            begin
                sum_wrap = sum - $signed({2'b00, HEADING_FULL});
            end
        end
        else if (sum[SUM_W-1])
        begin
            sum_wrap = sum + $signed({2'b00, HEADING_FULL});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                f1_valid_reg <= cordic_out_valid;
            end
            if (rdy2)
            begin
                f2_valid_reg <= f1_valid_reg;
            end
            if (rdy3)
            begin
                f3_valid_reg <= f2_valid_reg;
            end
            if (rdy4)
            begin
                f4_valid_reg <= f3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && cordic_out_valid)
        begin
            f1_num_reg  <= f1_num_next;
            f1_zero_reg <= cordic_out.zero;
        end
        if (rdy2 && f1_valid_reg)
        begin
            f2_q_reg    <= prod[RECIP_SHIFT +: HDG_W];
            f2_num_reg  <= f1_num_reg;
            f2_zero_reg <= f1_zero_reg;
        end
        if (rdy3 && f2_valid_reg)
        begin
            f3_base_reg <= f3_base_next;
        end
        if (rdy4 && f3_valid_reg)
        begin
            heading_reg <= sum_wrap[HDG_W-1:0];
        end
    end

    assign result.valid   = f4_valid_reg;
    assign result.heading = heading_reg;

endmodule

// File: hw/rtl/mhd_checker.sv
`include "magnetometer_heading_top_defines.svh"

module mhd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [mhd_pkg::HDG_W-1:0]  heading
);
    import mhd_pkg::*;

    // heading never leaves the circle, whatever the declination register holds
    `MHD_ASSERT_SAME(a_heading_range, out_valid, heading <= HEADING_FULL, "heading out of range")

    // an empty output stage means no stage can be blocking the input
    `MHD_ASSERT_SAME(a_ready_when_drained, !out_valid, in_ready, "input stalled, output empty")

    // a stalled result is held
    `MHD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(heading), "not held")

    // while the receiver takes every transaction the input is never refused
    `MHD_ASSERT_SAME(a_no_backpressure, out_ready, in_ready, "input refused while output drains")

endmodule

bind magnetometer_heading_top mhd_checker u_mhd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .heading   (result.heading)
);
